// ----- design/assert_macros.svh -----
// Assertion macros shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is asserted.
`define HRSE_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is asserted.
`define HRSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/hrse_pkg.sv -----
package hrse_pkg;

    // Number of key slots carried by one boot report.
    localparam int INPUT_KEYS = 6;
    // Modifier groups that produce a scancode: Ctrl, left Shift, right Shift, Alt.
    localparam int MOD_GROUPS = 4;

    localparam logic [3:0] LEN_MIN = 4'd3;
    localparam logic [3:0] LEN_MAX = 4'd8;

    localparam logic [7:0] BRK        = 8'h80;
    localparam logic [7:0] SC_CTRL    = 8'h1d;
    localparam logic [7:0] SC_SHIFT_L = 8'h2a;
    localparam logic [7:0] SC_SHIFT_R = 8'h36;
    localparam logic [7:0] SC_ALT     = 8'h38;
    localparam logic [7:0] SC_HOME    = 8'h47;
    localparam logic [7:0] SC_UP      = 8'h48;
    localparam logic [7:0] SC_DOWN    = 8'h50;

    localparam logic [7:0] MASK_CTRL    = 8'h11;
    localparam logic [7:0] MASK_SHIFT_L = 8'h02;
    localparam logic [7:0] MASK_SHIFT_R = 8'h20;
    localparam logic [7:0] MASK_ALT     = 8'h44;

    localparam logic [1:0] GRP_CTRL    = 2'd0;
    localparam logic [1:0] GRP_SHIFT_L = 2'd1;
    localparam logic [1:0] GRP_SHIFT_R = 2'd2;

    localparam logic [7:0] USAGE_CAPS = 8'h39;
    localparam logic [7:0] USAGE_END  = 8'h4d;
    localparam logic [7:0] USAGE_PGUP = 8'h4b;
    localparam logic [7:0] USAGE_PGDN = 8'h4e;
    localparam logic [7:0] USAGE_LO   = 8'h04;
    localparam logic [7:0] USAGE_HI   = 8'h64;

    localparam int MAP_DEPTH = 97;

    // Usage 0x04 to 0x64 to scancode; zero marks an unmapped usage.
    localparam logic [7:0] USAGE_MAP [MAP_DEPTH] = '{
        8'h1e, 8'h30, 8'h2e, 8'h20, 8'h12, 8'h21, 8'h22, 8'h23,
        8'h17, 8'h24, 8'h25, 8'h26, 8'h32, 8'h31, 8'h18, 8'h19,
        8'h10, 8'h13, 8'h1f, 8'h14, 8'h16, 8'h2f, 8'h11, 8'h2d,
        8'h15, 8'h2c, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07,
        8'h08, 8'h09, 8'h0a, 8'h0b, 8'h1c, 8'h01, 8'h0e, 8'h0f,
        8'h39, 8'h0c, 8'h0d, 8'h1a, 8'h1b, 8'h2b, 8'h2b, 8'h27,
        8'h28, 8'h29, 8'h33, 8'h34, 8'h35, 8'h3a, 8'h3b, 8'h3c,
        8'h3d, 8'h3e, 8'h3f, 8'h40, 8'h41, 8'h42, 8'h43, 8'h44,
        8'h62, 8'h61, 8'h63, 8'h00, 8'h64, 8'h52, 8'h47, 8'h00,
        8'h53, 8'h00, 8'h00, 8'h4d, 8'h4b, 8'h50, 8'h48, 8'h00,
        8'h65, 8'h66, 8'h4a, 8'h4e, 8'h72, 8'h6d, 8'h6e, 8'h6f,
        8'h6a, 8'h6b, 8'h6c, 8'h67, 8'h68, 8'h69, 8'h70, 8'h71,
        8'h60
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD_BRK,
        ST_MOD_MAKE,
        ST_KEY_BRK,
        ST_KEY_MAKE,
        ST_FINISH
    } t_ctrl_state;

    typedef struct packed {
        logic        load;
        logic        step;
        t_ctrl_state phase;
        logic        sub;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic rpt_ok;
        logic key_ext;
    } t_dp_sts;

    function automatic logic [7:0] map_usage(input logic [7:0] u);
        logic [7:0] sc;
        if (u < USAGE_LO || u > USAGE_HI) begin
            sc = 8'h00;
        end else begin
            sc = USAGE_MAP[7'(u - USAGE_LO)];
        end
        return sc;
    endfunction

    function automatic logic [7:0] ext_scan(input logic [7:0] u);
        logic [7:0] sc;
        case (u)
            USAGE_END:  sc = SC_HOME;
            USAGE_PGUP: sc = SC_UP;
            default:    sc = SC_DOWN;
        endcase
        return sc;
    endfunction

    function automatic logic [7:0] mod_mask(input logic [1:0] g);
        logic [7:0] m;
        case (g)
            GRP_CTRL:    m = MASK_CTRL;
            GRP_SHIFT_L: m = MASK_SHIFT_L;
            GRP_SHIFT_R: m = MASK_SHIFT_R;
            default:     m = MASK_ALT;
        endcase
        return m;
    endfunction

    function automatic logic [7:0] mod_scan(input logic [1:0] g);
        logic [7:0] sc;
        case (g)
            GRP_CTRL:    sc = SC_CTRL;
            GRP_SHIFT_L: sc = SC_SHIFT_L;
            GRP_SHIFT_R: sc = SC_SHIFT_R;
            default:     sc = SC_ALT;
        endcase
        return sc;
    endfunction

endpackage

// ----- design/hrse_if.sv -----
// Report request channel.
interface hrse_req_if;
    logic       valid;
    logic       ready;
    logic       transfer_ok;
    logic [3:0] report_length;
    logic [7:0] modifier_bits;
    logic [7:0] key_0;
    logic [7:0] key_1;
    logic [7:0] key_2;
    logic [7:0] key_3;
    logic [7:0] key_4;
    logic [7:0] key_5;

    modport source (
        output valid, transfer_ok, report_length, modifier_bits,
        output key_0, key_1, key_2, key_3, key_4, key_5,
        input  ready
    );
    modport sink (
        input  valid, transfer_ok, report_length, modifier_bits,
        input  key_0, key_1, key_2, key_3, key_4, key_5,
        output ready
    );
endinterface

// Scancode event channel.
interface hrse_evt_if;
    logic       valid;
    logic       ready;
    logic [7:0] scancode;
    logic       scancode_valid;
    logic       caps_led_on;
    logic       led_changed;
    logic       last;

    modport source (
        output valid, scancode, scancode_valid, caps_led_on, led_changed, last,
        input  ready
    );
    modport sink (
        input  valid, scancode, scancode_valid, caps_led_on, led_changed, last,
        output ready
    );
endinterface

// ----- design/hrse_ctrl.sv -----
`include "assert_macros.svh"

module hrse_ctrl #(
    parameter  int KEY_SLOTS = 6,
    localparam int IDX_W     = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1,
    localparam int CNT_W     = (IDX_W > 2) ? IDX_W : 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    output logic               o_req_ready,
    input  hrse_pkg::t_dp_sts  i_sts,
    output hrse_pkg::t_dp_cmd  o_cmd,
    output logic [CNT_W-1:0]   o_idx
);

    localparam logic [CNT_W-1:0] MOD_LAST  = CNT_W'(hrse_pkg::MOD_GROUPS - 1);
    localparam logic [CNT_W-1:0] SLOT_LAST = CNT_W'(KEY_SLOTS - 1);

    hrse_pkg::t_ctrl_state r_state;
    hrse_pkg::t_ctrl_state n_state;
    logic [CNT_W-1:0]      r_idx;
    logic [CNT_W-1:0]      n_idx;
    logic                  r_sub;
    logic                  n_sub;
    logic                  w_step;

    assign w_step = i_sts.out_free;

    // Next state.
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_sub   = r_sub;
        case (r_state)
            hrse_pkg::ST_IDLE: begin
                if (i_req_valid && i_sts.rpt_ok) begin
                    n_state = hrse_pkg::ST_MOD_BRK;
                    n_idx   = '0;
                    n_sub   = 1'b0;
                end
            end
            hrse_pkg::ST_MOD_BRK: begin
                if (w_step) begin
                    if (r_idx == MOD_LAST) begin
                        n_state = hrse_pkg::ST_MOD_MAKE;
                        n_idx   = '0;
                    end else begin
                        n_idx = r_idx + CNT_W'(1);
                    end
                end
            end
            hrse_pkg::ST_MOD_MAKE: begin
                if (w_step) begin
                    if (r_idx == MOD_LAST) begin
                        n_state = hrse_pkg::ST_KEY_BRK;
                        n_idx   = '0;
                    end else begin
                        n_idx = r_idx + CNT_W'(1);
                    end
                end
            end
            hrse_pkg::ST_KEY_BRK: begin
                if (w_step) begin
                    if (i_sts.key_ext && !r_sub) begin
                        n_sub = 1'b1;
                    end else begin
                        n_sub = 1'b0;
                        if (r_idx == SLOT_LAST) begin
                            n_state = hrse_pkg::ST_KEY_MAKE;
                            n_idx   = '0;
                        end else begin
                            n_idx = r_idx + CNT_W'(1);
                        end
                    end
                end
            end
            hrse_pkg::ST_KEY_MAKE: begin
                if (w_step) begin
                    if (i_sts.key_ext && !r_sub) begin
                        n_sub = 1'b1;
                    end else begin
                        n_sub = 1'b0;
                        if (r_idx == SLOT_LAST) begin
                            n_state = hrse_pkg::ST_FINISH;
                            n_idx   = '0;
                        end else begin
                            n_idx = r_idx + CNT_W'(1);
                        end
                    end
                end
            end
            hrse_pkg::ST_FINISH: begin
                if (w_step) begin
                    n_state = hrse_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = hrse_pkg::ST_IDLE;
                n_idx   = '0;
                n_sub   = 1'b0;
            end
        endcase
    end

    // Outputs.
    always_comb begin
        o_req_ready = (r_state == hrse_pkg::ST_IDLE);
        o_cmd.load  = (r_state == hrse_pkg::ST_IDLE) && i_req_valid && i_sts.rpt_ok;
        o_cmd.step  = (r_state != hrse_pkg::ST_IDLE) && w_step;
        o_cmd.phase = r_state;
        o_cmd.sub   = r_sub;
        o_idx       = r_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hrse_pkg::ST_IDLE;
            r_idx   <= '0;
            r_sub   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_sub   <= n_sub;
        end
    end

    `HRSE_ASSERT_NEXT(a_drop_stays_idle, i_clk, i_rst_n,
        i_req_valid && o_req_ready && !i_sts.rpt_ok, r_state == hrse_pkg::ST_IDLE,
        "dropped report started a sequence")
    `HRSE_ASSERT_SAME(a_sub_in_key_phase, i_clk, i_rst_n, r_sub,
        r_state == hrse_pkg::ST_KEY_BRK || r_state == hrse_pkg::ST_KEY_MAKE,
        "second half of an extended key outside a key phase")

endmodule

// ----- design/hrse_dp.sv -----
`include "assert_macros.svh"

module hrse_dp #(
    parameter  int KEY_SLOTS = 6,
    localparam int IDX_W     = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1,
    localparam int CNT_W     = (IDX_W > 2) ? IDX_W : 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_transfer_ok,
    input  logic [3:0]        i_report_length,
    input  logic [7:0]        i_modifier_bits,
    input  logic [7:0]        i_keys [hrse_pkg::INPUT_KEYS],
    input  hrse_pkg::t_dp_cmd i_cmd,
    input  logic [CNT_W-1:0]  i_idx,
    output hrse_pkg::t_dp_sts o_sts,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [7:0]        o_scancode,
    output logic              o_scancode_valid,
    output logic              o_caps_led_on,
    output logic              o_led_changed,
    output logic              o_last
);

    // Report being worked on and the previous accepted report.
    logic [7:0] r_mods;
    logic [7:0] r_cur [KEY_SLOTS];
    logic [7:0] r_prev_mods;
    logic [7:0] r_prev_keys [KEY_SLOTS];
    logic       r_caps;
    logic       n_caps;

    // Item held back until it is known whether another one follows.
    logic       r_hold_vld;
    logic       n_hold_vld;
    logic [7:0] r_hold_sc;
    logic       r_hold_led;
    logic       r_hold_chg;

    logic       r_out_vld;
    logic       n_out_vld;
    logic [7:0] r_out_sc;
    logic       r_out_scv;
    logic       r_out_led;
    logic       r_out_chg;
    logic       r_out_last;

    logic [7:0]       w_cur [KEY_SLOTS];
    logic [IDX_W-1:0] w_slot;
    logic [1:0]       w_grp;
    logic [7:0]       w_key;
    logic [7:0]       w_map;
    logic [7:0]       w_mod_diff;
    logic             w_brk_phase;
    logic             w_in_cur;
    logic             w_in_prev;
    logic             w_active;
    logic             w_ext;
    logic             w_emit;
    logic [7:0]       w_sc;
    logic             w_chg;
    logic             w_toggle;
    logic             w_finish;
    logic             w_emit_step;
    logic             w_out_load;

    // Slots beyond the report length, or beyond the report itself, read as zero.
    for (genvar s = 0; s < KEY_SLOTS; s++) begin : g_cur
        if (s < hrse_pkg::INPUT_KEYS) begin : g_in
            assign w_cur[s] = (i_report_length > 4'(s + 2)) ? i_keys[s] : 8'h00;
        end else begin : g_zero
            assign w_cur[s] = 8'h00;
        end
    end

    assign w_slot      = i_idx[IDX_W-1:0];
    assign w_grp       = i_idx[1:0];
    assign w_brk_phase = (i_cmd.phase == hrse_pkg::ST_MOD_BRK)
                      || (i_cmd.phase == hrse_pkg::ST_KEY_BRK);
    assign w_key       = (i_cmd.phase == hrse_pkg::ST_KEY_BRK) ? r_prev_keys[w_slot]
                                                               : r_cur[w_slot];
    assign w_map       = hrse_pkg::map_usage(w_key);
    assign w_ext       = w_key inside {hrse_pkg::USAGE_END, hrse_pkg::USAGE_PGUP,
                                       hrse_pkg::USAGE_PGDN};
    assign w_mod_diff  = (i_cmd.phase == hrse_pkg::ST_MOD_BRK) ? (r_prev_mods & ~r_mods)
                                                               : (r_mods & ~r_prev_mods);

    // A released key must be absent from the new report, a pressed key from the old one.
    always_comb begin
        w_in_cur  = 1'b0;
        w_in_prev = 1'b0;
        for (int j = 0; j < KEY_SLOTS; j++) begin
            w_in_cur  = w_in_cur  | (r_cur[j] == w_key);
            w_in_prev = w_in_prev | (r_prev_keys[j] == w_key);
        end
    end

    assign w_active = (w_key != 8'h00)
                   && !((i_cmd.phase == hrse_pkg::ST_KEY_BRK) ? w_in_cur : w_in_prev);

    always_comb begin
        w_emit   = 1'b0;
        w_sc     = 8'h00;
        w_chg    = 1'b0;
        w_toggle = 1'b0;
        case (i_cmd.phase)
            hrse_pkg::ST_MOD_BRK, hrse_pkg::ST_MOD_MAKE: begin
                w_emit = |(w_mod_diff & hrse_pkg::mod_mask(w_grp));
                w_sc   = hrse_pkg::mod_scan(w_grp) | (w_brk_phase ? hrse_pkg::BRK : 8'h00);
            end
            hrse_pkg::ST_KEY_BRK: begin
                if (w_active) begin
                    if (w_ext) begin
                        w_emit = 1'b1;
                        w_sc   = (i_cmd.sub ? hrse_pkg::SC_SHIFT_L : hrse_pkg::ext_scan(w_key))
                               | hrse_pkg::BRK;
                    end else begin
                        w_emit = (w_map != 8'h00);
                        w_sc   = w_map | hrse_pkg::BRK;
                    end
                end
            end
            hrse_pkg::ST_KEY_MAKE: begin
                if (w_active) begin
                    w_toggle = (w_key == hrse_pkg::USAGE_CAPS);
                    if (w_ext) begin
                        w_emit = 1'b1;
                        w_sc   = i_cmd.sub ? hrse_pkg::ext_scan(w_key) : hrse_pkg::SC_SHIFT_L;
                    end else begin
                        w_emit = (w_map != 8'h00);
                        w_sc   = w_map;
                        w_chg  = w_toggle;
                    end
                end
            end
            default: begin
                w_emit = 1'b0;
            end
        endcase
    end

    assign w_finish    = i_cmd.step && (i_cmd.phase == hrse_pkg::ST_FINISH);
    assign w_emit_step = i_cmd.step && w_emit;
    assign w_out_load  = w_finish || (w_emit_step && r_hold_vld);

    always_comb begin
        n_out_vld  = w_out_load ? 1'b1 : (r_out_vld && !i_out_ready);
        n_hold_vld = w_finish ? 1'b0 : (w_emit_step ? 1'b1 : r_hold_vld);
        n_caps     = (i_cmd.step && w_toggle) ? ~r_caps : r_caps;
    end

    assign o_sts.out_free = !r_out_vld || i_out_ready;
    assign o_sts.rpt_ok   = i_transfer_ok
                         && (i_report_length inside {[hrse_pkg::LEN_MIN:hrse_pkg::LEN_MAX]});
    assign o_sts.key_ext  = w_active && w_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld   <= 1'b0;
            r_hold_vld  <= 1'b0;
            r_caps      <= 1'b0;
            r_prev_mods <= 8'h00;
            for (int j = 0; j < KEY_SLOTS; j++) begin
                r_prev_keys[j] <= 8'h00;
            end
        end else begin
            r_out_vld  <= n_out_vld;
            r_hold_vld <= n_hold_vld;
            r_caps     <= n_caps;
            if (w_finish) begin
                r_prev_mods <= r_mods;
                r_prev_keys <= r_cur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mods <= i_modifier_bits;
            r_cur  <= w_cur;
        end
        if (w_emit_step) begin
            r_hold_sc  <= w_sc;
            r_hold_led <= r_caps ^ w_toggle;
            r_hold_chg <= w_chg;
        end
        if (w_out_load) begin
            if (w_finish && !r_hold_vld) begin
                r_out_sc  <= 8'h00;
                r_out_scv <= 1'b0;
                r_out_led <= r_caps;
                r_out_chg <= 1'b0;
            end else begin
                r_out_sc  <= r_hold_sc;
                r_out_scv <= 1'b1;
                r_out_led <= r_hold_led;
                r_out_chg <= r_hold_chg;
            end
            r_out_last <= w_finish;
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_scancode       = r_out_sc;
    assign o_scancode_valid = r_out_scv;
    assign o_caps_led_on    = r_out_led;
    assign o_led_changed    = r_out_chg;
    assign o_last           = r_out_last;

    `HRSE_ASSERT_NEXT(a_caps_only_on_press, i_clk, i_rst_n,
        !(i_cmd.step && i_cmd.phase == hrse_pkg::ST_KEY_MAKE), $stable(r_caps),
        "Caps Lock LED changed outside a key press step")
    `HRSE_ASSERT_SAME(a_marker_is_last, i_clk, i_rst_n, r_out_vld && !r_out_scv, r_out_last,
        "marker item not flagged as last")

endmodule

// ----- design/hid_report_to_scancode_events.sv -----
// Boot keyboard report to scancode events. Each request on i_req is one boot keyboard
// report; it is compared with the previous accepted report and the differences leave on
// o_evt as make and break scancodes, in this order: released modifiers, pressed
// modifiers, released keys, pressed keys. End, PageUp and PageDown are sent as shifted
// Home, Up and Down, and every new Caps Lock press toggles the LED bit that travels with
// each event. A report with a failed transfer or a length outside 3 to 8 is taken and
// dropped without touching the stored state. A report that changes nothing visible yields
// one marker event with scancode_valid low. The last event of a report has last set. A
// sequencer walks the report one step per cycle while the output register is free: four
// modifier groups for releases and four for presses, KEY_SLOTS release slots, KEY_SLOTS
// press slots, one extra step for every changed End, PageUp or PageDown, and a closing
// step. Each step needs the single output register to be free, so back-pressure on o_evt
// stretches the sequence. A new report is taken as soon as the previous one has closed,
// even while its last event still waits in the output register. At most 32 events come
// from one report.
module hid_report_to_scancode_events #(
    parameter int KEY_SLOTS = 6
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    hrse_req_if.sink      i_req,
    hrse_evt_if.source    o_evt
);

    localparam int IDX_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
    localparam int CNT_W = (IDX_W > 2) ? IDX_W : 2;

    hrse_pkg::t_dp_cmd w_cmd;
    hrse_pkg::t_dp_sts w_sts;
    logic [CNT_W-1:0]  w_idx;
    logic              w_ready;
    logic [7:0]        w_keys [hrse_pkg::INPUT_KEYS];

    // Key slots of the request as an array for the datapath.
    assign w_keys[0] = i_req.key_0;
    assign w_keys[1] = i_req.key_1;
    assign w_keys[2] = i_req.key_2;
    assign w_keys[3] = i_req.key_3;
    assign w_keys[4] = i_req.key_4;
    assign w_keys[5] = i_req.key_5;

    assign i_req.ready = w_ready;

    // The controller decides which step runs; the datapath holds the reports, compares
    // them, and owns the held-back event and the output register.
    hrse_ctrl #(
        .KEY_SLOTS (KEY_SLOTS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (w_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_idx       (w_idx)
    );

    hrse_dp #(
        .KEY_SLOTS (KEY_SLOTS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_transfer_ok    (i_req.transfer_ok),
        .i_report_length  (i_req.report_length),
        .i_modifier_bits  (i_req.modifier_bits),
        .i_keys           (w_keys),
        .i_cmd            (w_cmd),
        .i_idx            (w_idx),
        .o_sts            (w_sts),
        .i_out_ready      (o_evt.ready),
        .o_out_valid      (o_evt.valid),
        .o_scancode       (o_evt.scancode),
        .o_scancode_valid (o_evt.scancode_valid),
        .o_caps_led_on    (o_evt.caps_led_on),
        .o_led_changed    (o_evt.led_changed),
        .o_last           (o_evt.last)
    );

endmodule

// ----- tb/sv/tb_hid_report_to_scancode_events.sv -----
`timescale 1ns / 1ps

module tb_hid_report_to_scancode_events;
    import hrse_pkg::*;

    localparam int CLK_HIGH       = 6;
    localparam int CLK_LOW        = 6;
    localparam int RESET_CYCLES   = 10;
    localparam int RANDOM_REPORTS = 250;
    localparam int MAX_EVENTS     = 32;
    // The tail leaves room for a stray event.
    localparam int TAIL_CYCLES    = 48;
    localparam int HOLD_CYCLES    = 400;
    localparam int RUSH_REPORTS   = 16;
    localparam int HOLD_AT        = 90;
    localparam int DRAIN_AT       = 190;
    // Longest quiet spell of a correct run is the deliberate hold-off plus one report.
    localparam int STALL_LIMIT    = 3000;

    // One boot keyboard report, field for field as it travels on the request channel.
    typedef struct packed {
        logic       transfer_ok;
        logic [3:0] report_length;
        logic [7:0] modifier_bits;
        logic [7:0] key_0;
        logic [7:0] key_1;
        logic [7:0] key_2;
        logic [7:0] key_3;
        logic [7:0] key_4;
        logic [7:0] key_5;
    } t_report;

    typedef struct packed {
        logic [7:0] scancode;
        logic       scancode_valid;
        logic       caps_led_on;
        logic       led_changed;
        logic       last;
    } t_event;

    // A row of the directed plan. Where typed is set, the number of events and the
    // single event are written in by hand and take the place of the prediction.
    typedef struct packed {
        t_report    rpt;
        logic       typed;
        logic [1:0] n_evt;
        t_event     ev;
    } t_row;

    localparam t_event NO_EVENT   = '0;
    localparam t_event MARKER_OFF = '{8'h00, 1'b0, 1'b0, 1'b0, 1'b1};

    // Usage 0x04 to 0x64 to set 1 scancode; zero marks a usage with no scancode.
    localparam logic [7:0] SCAN_OF_USAGE [97] = '{
        8'h1e, 8'h30, 8'h2e, 8'h20, 8'h12, 8'h21, 8'h22, 8'h23,
        8'h17, 8'h24, 8'h25, 8'h26, 8'h32, 8'h31, 8'h18, 8'h19,
        8'h10, 8'h13, 8'h1f, 8'h14, 8'h16, 8'h2f, 8'h11, 8'h2d,
        8'h15, 8'h2c, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07,
        8'h08, 8'h09, 8'h0a, 8'h0b, 8'h1c, 8'h01, 8'h0e, 8'h0f,
        8'h39, 8'h0c, 8'h0d, 8'h1a, 8'h1b, 8'h2b, 8'h2b, 8'h27,
        8'h28, 8'h29, 8'h33, 8'h34, 8'h35, 8'h3a, 8'h3b, 8'h3c,
        8'h3d, 8'h3e, 8'h3f, 8'h40, 8'h41, 8'h42, 8'h43, 8'h44,
        8'h62, 8'h61, 8'h63, 8'h00, 8'h64, 8'h52, 8'h47, 8'h00,
        8'h53, 8'h00, 8'h00, 8'h4d, 8'h4b, 8'h50, 8'h48, 8'h00,
        8'h65, 8'h66, 8'h4a, 8'h4e, 8'h72, 8'h6d, 8'h6e, 8'h6f,
        8'h6a, 8'h6b, 8'h6c, 8'h67, 8'h68, 8'h69, 8'h70, 8'h71,
        8'h60
    };

    // The directed plan starts from the reset state and walks through drops, modifier
    // extremes, short reports, Caps Lock, the navigation keys, keys with no scancode,
    // repeated usages and a report that yields thirty events.
    localparam t_row DIRECTED_PLAN [24] = '{
        // Nothing held and nothing new straight after reset: the marker.
        '{'{1'b1, 4'd8, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, 2'd1, MARKER_OFF},
        // Failed transfers and lengths outside the window are dropped silently.
        '{'{1'b0, 4'd8, 8'hff, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09}, 1'b1, 2'd0, NO_EVENT},
        '{'{1'b1, 4'd0, 8'hff, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09}, 1'b1, 2'd0, NO_EVENT},
        '{'{1'b1, 4'd2, 8'hff, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09}, 1'b1, 2'd0, NO_EVENT},
        '{'{1'b1, 4'd9, 8'hff, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09}, 1'b1, 2'd0, NO_EVENT},
        '{'{1'b1, 4'd15, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff}, 1'b1, 2'd0, NO_EVENT},
        // Only the two modifier bits that carry no scancode: still the marker.
        '{'{1'b1, 4'd3, 8'h88, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, 2'd1, MARKER_OFF},
        '{'{1'b1, 4'd8, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, 2'd0, NO_EVENT},
        '{'{1'b1, 4'd8, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, 2'd0, NO_EVENT},
        '{'{1'b1, 4'd8, 8'h0f, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, 2'd0, NO_EVENT},
        '{'{1'b1, 4'd8, 8'h70, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, 2'd0, NO_EVENT},
        '{'{1'b1, 4'd8, 8'h00, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09}, 1'b0, 2'd0, NO_EVENT},
        // Short reports: slots past the length read as empty.
        '{'{1'b1, 4'd3, 8'h00, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09}, 1'b0, 2'd0, NO_EVENT},
        '{'{1'b1, 4'd5, 8'h00, USAGE_CAPS, 8'h00, 8'h00, 8'h2c, 8'h2d, 8'h2e},
          1'b0, 2'd0, NO_EVENT},
        '{'{1'b1, 4'd8, 8'h00, USAGE_CAPS, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00},
          1'b0, 2'd0, NO_EVENT},
        '{'{1'b1, 4'd8, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, 2'd0, NO_EVENT},
        '{'{1'b1, 4'd8, 8'h00, USAGE_CAPS, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
          1'b0, 2'd0, NO_EVENT},
        '{'{1'b1, 4'd8, 8'h00, USAGE_END, USAGE_PGUP, USAGE_PGDN, 8'h00, 8'h00, 8'h00},
          1'b0, 2'd0, NO_EVENT},
        '{'{1'b1, 4'd8, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, 2'd0, NO_EVENT},
        // Usages with no scancode, below and above the table and a hole inside it.
        '{'{1'b1, 4'd8, 8'h00, 8'h01, 8'h47, 8'h65, 8'hff, 8'h02, 8'h03}, 1'b1, 2'd1, MARKER_OFF},
        // The same usage in every slot is handled once per slot.
        '{'{1'b1, 4'd8, 8'h00, 8'h04, 8'h04, 8'h04, 8'h04, 8'h04, 8'h04}, 1'b0, 2'd0, NO_EVENT},
        '{'{1'b1, 4'd8, 8'h07, USAGE_END, USAGE_END, USAGE_END, USAGE_PGUP, USAGE_PGUP,
            USAGE_PGUP}, 1'b0, 2'd0, NO_EVENT},
        '{'{1'b1, 4'd8, 8'h70, USAGE_PGDN, USAGE_PGDN, USAGE_PGDN, USAGE_PGDN, USAGE_PGDN,
            USAGE_PGDN}, 1'b0, 2'd0, NO_EVENT},
        '{'{1'b1, 4'd8, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, 2'd0, NO_EVENT}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    hrse_req_if req_bus ();
    hrse_evt_if evt_bus ();

    hid_report_to_scancode_events DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus.sink),
        .o_evt   (evt_bus.source)
    );

    always begin
        #CLK_HIGH i_clk = 1'b1;
        #CLK_LOW  i_clk = 1'b0;
    end

    // Keyboard image held by the predictor: what the block should have stored.
    logic [7:0]                  held_mods = 8'h00;
    logic [INPUT_KEYS-1:0][7:0]  held_keys = '0;
    logic                        caps_state = 1'b0;

    // Events of the report in hand, and every event still owed by the block.
    t_event report_events [$];
    t_event expected_events [$];

    // Shape of the random typing: the keys and modifiers that the imaginary user holds.
    logic [7:0]                  typing_mods = 8'h00;
    logic [INPUT_KEYS-1:0][7:0]  typing_keys = '0;

    int unsigned fault_count = 0;
    int          burst_left  = 0;
    int          rush_left   = 0;
    int          stall_count = 0;
    bit          hold_off_req = 1'b0;

    function automatic void queue_code(input logic [7:0] sc, input logic led_toggle);
        t_event ev;
        if (report_events.size() >= MAX_EVENTS) return;
        ev = '{sc, 1'b1, caps_state, led_toggle, 1'b0};
        report_events.push_back(ev);
    endfunction

    function automatic void queue_modifiers(input logic [7:0] m, input logic [7:0] brk);
        if ((m & MASK_CTRL) != 8'h00)    queue_code(SC_CTRL | brk, 1'b0);
        if ((m & MASK_SHIFT_L) != 8'h00) queue_code(SC_SHIFT_L | brk, 1'b0);
        if ((m & MASK_SHIFT_R) != 8'h00) queue_code(SC_SHIFT_R | brk, 1'b0);
        if ((m & MASK_ALT) != 8'h00)     queue_code(SC_ALT | brk, 1'b0);
    endfunction

    function automatic logic [7:0] usage_scan(input logic [7:0] u);
        if (u < USAGE_LO || u > USAGE_HI) return 8'h00;
        return SCAN_OF_USAGE[u - USAGE_LO];
    endfunction

    function automatic logic is_nav(input logic [7:0] u);
        return (u == USAGE_END) || (u == USAGE_PGUP) || (u == USAGE_PGDN);
    endfunction

    // End, PageUp and PageDown travel as Home, Up and Down under a left Shift.
    function automatic logic [7:0] nav_scan(input logic [7:0] u);
        if (u == USAGE_END)  return SC_HOME;
        if (u == USAGE_PGUP) return SC_UP;
        return SC_DOWN;
    endfunction

    function automatic logic key_in(input logic [INPUT_KEYS-1:0][7:0] keys,
                                    input logic [7:0] u);
        for (int j = 0; j < INPUT_KEYS; j++) begin
            if (keys[j] == u) return 1'b1;
        end
        return 1'b0;
    endfunction

    // Works out the events of one report into report_events and moves the keyboard
    // image on. Returns the number of events; a dropped report has none.
    function automatic int predict_report(input t_report r);
        logic [INPUT_KEYS-1:0][7:0] raw;
        logic [INPUT_KEYS-1:0][7:0] cur;
        logic [7:0]                 k;
        t_event                     ev;
        report_events.delete();
        if (!r.transfer_ok || r.report_length < LEN_MIN || r.report_length > LEN_MAX) begin
            return 0;
        end
        raw[0] = r.key_0;
        raw[1] = r.key_1;
        raw[2] = r.key_2;
        raw[3] = r.key_3;
        raw[4] = r.key_4;
        raw[5] = r.key_5;
        for (int i = 0; i < INPUT_KEYS; i++) begin
            cur[i] = (i + 2 < int'(r.report_length)) ? raw[i] : 8'h00;
        end

        queue_modifiers(held_mods & ~r.modifier_bits, BRK);
        queue_modifiers(r.modifier_bits & ~held_mods, 8'h00);

        for (int i = 0; i < INPUT_KEYS; i++) begin
            k = held_keys[i];
            if (k != 8'h00 && !key_in(cur, k)) begin
                if (is_nav(k)) begin
                    queue_code(nav_scan(k) | BRK, 1'b0);
                    queue_code(SC_SHIFT_L | BRK, 1'b0);
                end else if (usage_scan(k) != 8'h00) begin
                    queue_code(usage_scan(k) | BRK, 1'b0);
                end
            end
        end

        for (int i = 0; i < INPUT_KEYS; i++) begin
            k = cur[i];
            if (k != 8'h00 && !key_in(held_keys, k)) begin
                // The LED flips before the make code leaves, so that event carries it.
                if (k == USAGE_CAPS) caps_state = ~caps_state;
                if (is_nav(k)) begin
                    queue_code(SC_SHIFT_L, 1'b0);
                    queue_code(nav_scan(k), 1'b0);
                end else if (usage_scan(k) != 8'h00) begin
                    queue_code(usage_scan(k), k == USAGE_CAPS);
                end
            end
        end

        held_mods = r.modifier_bits;
        held_keys = cur;

        if (report_events.size() == 0) begin
            ev = '{8'h00, 1'b0, caps_state, 1'b0, 1'b1};
            report_events.push_back(ev);
        end else begin
            report_events[report_events.size() - 1].last = 1'b1;
        end
        return report_events.size();
    endfunction

    function automatic logic [7:0] pick_usage();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll < 11) return 8'($urandom_range(USAGE_LO, USAGE_HI));
        case (roll)
            11: return USAGE_CAPS;
            12: return USAGE_END;
            13: return USAGE_PGUP;
            14: return USAGE_PGDN;
            15, 16: return 8'h00;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Most random reports follow a user typing: at most one key or modifier changes from the
    // last report. The rest are dropped reports and reports of random bytes.
    function automatic t_report random_report();
        t_report r;
        int      roll;
        roll = $urandom_range(0, 99);
        r.transfer_ok   = 1'b1;
        r.report_length = 4'($urandom_range(0, 15));
        r.modifier_bits = 8'($urandom);
        {r.key_0, r.key_1, r.key_2} = 24'($urandom);
        {r.key_3, r.key_4, r.key_5} = 24'($urandom);
        if (roll < 12) begin
            r.transfer_ok = 1'($urandom_range(0, 1));
            if (r.transfer_ok && r.report_length >= LEN_MIN && r.report_length <= LEN_MAX) begin
                r.report_length = ($urandom_range(0, 1) != 0) ? 4'($urandom_range(0, 2))
                                                               : 4'($urandom_range(9, 15));
            end
        end else if (roll < 22) begin
            r.report_length = 4'($urandom_range(LEN_MIN, LEN_MAX));
        end else begin
            case ($urandom_range(0, 5))
                0, 1, 2: typing_keys[$urandom_range(0, INPUT_KEYS - 1)] = pick_usage();
                3:       typing_keys[$urandom_range(0, INPUT_KEYS - 1)] = 8'h00;
                4:       typing_mods = typing_mods ^ 8'(1 << $urandom_range(0, 7));
                default: ;
            endcase
            r.report_length = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(LEN_MIN, 7))
                                                          : LEN_MAX;
            r.modifier_bits = typing_mods;
            r.key_0 = typing_keys[0];
            r.key_1 = typing_keys[1];
            r.key_2 = typing_keys[2];
            r.key_3 = typing_keys[3];
            r.key_4 = typing_keys[4];
            r.key_5 = typing_keys[5];
        end
        return r;
    endfunction

    // Presents one request and returns at the edge where the block takes it.
    task automatic send_report(input t_report r);
        req_bus.valid         <= 1'b1;
        req_bus.transfer_ok   <= r.transfer_ok;
        req_bus.report_length <= r.report_length;
        req_bus.modifier_bits <= r.modifier_bits;
        req_bus.key_0         <= r.key_0;
        req_bus.key_1         <= r.key_1;
        req_bus.key_2         <= r.key_2;
        req_bus.key_3         <= r.key_3;
        req_bus.key_4         <= r.key_4;
        req_bus.key_5         <= r.key_5;
        do @(posedge i_clk); while (!req_bus.ready);
    endtask

    // Bursts of back-to-back requests with quiet gaps between them. During a rush
    // there are no gaps at all, so the block is kept full while its output is held.
    task automatic pace_sender();
        int gap;
        gap = 0;
        if (rush_left > 0) begin
            rush_left--;
        end else if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 6);
            gap = $urandom_range(1, 10);
        end
        if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic void compare_field(input string field, input logic [7:0] exp_val,
                                          input logic [7:0] act_val);
        if (act_val !== exp_val) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, exp_val,
                     act_val);
            fault_count++;
        end
    endfunction

    // Reset, then the directed plan, then the random reports, then the drain.
    initial begin : report_source
        t_report rpt;
        int      n;
        i_rst_n               <= 1'b0;
        req_bus.valid         <= 1'b0;
        req_bus.transfer_ok   <= 1'b0;
        req_bus.report_length <= 4'd0;
        req_bus.modifier_bits <= 8'h00;
        req_bus.key_0         <= 8'h00;
        req_bus.key_1         <= 8'h00;
        req_bus.key_2         <= 8'h00;
        req_bus.key_3         <= 8'h00;
        req_bus.key_4         <= 8'h00;
        req_bus.key_5         <= 8'h00;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED_PLAN[i]) begin
            send_report(DIRECTED_PLAN[i].rpt);
            n = predict_report(DIRECTED_PLAN[i].rpt);
            if (DIRECTED_PLAN[i].typed) begin
                if (n != int'(DIRECTED_PLAN[i].n_evt)) begin
                    $display("%0t: event count of plan row %0d, expected %0d, actual %0d",
                             $time, i, DIRECTED_PLAN[i].n_evt, n);
                    fault_count++;
                end
                report_events.delete();
                if (DIRECTED_PLAN[i].n_evt != 2'd0) report_events.push_back(DIRECTED_PLAN[i].ev);
            end
            foreach (report_events[j]) expected_events.push_back(report_events[j]);
            pace_sender();
        end

        for (int i = 0; i < RANDOM_REPORTS; i++) begin
            // Ask the receiver for a long hold-off and keep requests coming meanwhile.
            if (i == HOLD_AT) begin
                hold_off_req = 1'b1;
                rush_left    = RUSH_REPORTS;
            end
            // Let the block run completely dry once in the middle of the run.
            if (i == DRAIN_AT) begin
                req_bus.valid <= 1'b0;
                do @(posedge i_clk); while (expected_events.size() != 0);
            end
            rpt = random_report();
            send_report(rpt);
            void'(predict_report(rpt));
            foreach (report_events[j]) expected_events.push_back(report_events[j]);
            pace_sender();
        end

        req_bus.valid <= 1'b0;
        while (expected_events.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fault_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // The receiver switches between manners: always ready, half the time, rarely, or
    // mostly. On request it holds off for a long stretch.
    initial begin : event_sink
        int mode;
        int mode_left;
        mode      = 0;
        mode_left = 0;
        evt_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                evt_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                case (mode)
                    0:       evt_bus.ready <= 1'b1;
                    1:       evt_bus.ready <= 1'($urandom_range(0, 1));
                    2:       evt_bus.ready <= ($urandom_range(0, 3) == 0);
                    default: evt_bus.ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // Every event taken from the block is matched against the oldest one owed.
    always @(posedge i_clk) begin : event_checker
        t_event owed;
        if (i_rst_n && evt_bus.valid && evt_bus.ready) begin
            if (expected_events.size() == 0) begin
                $display("%0t: unexpected event, expected none, actual scancode %h", $time,
                         evt_bus.scancode);
                fault_count++;
            end else begin
                owed = expected_events.pop_front();
                compare_field("scancode", owed.scancode, evt_bus.scancode);
                compare_field("scancode_valid", 8'(owed.scancode_valid),
                              8'(evt_bus.scancode_valid));
                compare_field("caps_led_on", 8'(owed.caps_led_on), 8'(evt_bus.caps_led_on));
                compare_field("led_changed", 8'(owed.led_changed), 8'(evt_bus.led_changed));
                compare_field("last", 8'(owed.last), 8'(evt_bus.last));
            end
        end
    end

    // Ends a run in which neither channel has moved for far longer than any correct
    // behaviour allows.
    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (req_bus.valid && req_bus.ready) || (evt_bus.valid && evt_bus.ready)) begin
            stall_count <= 0;
        end else if (stall_count >= STALL_LIMIT) begin
            $display("%0t: no request moved for %0d cycles", $time, STALL_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            stall_count <= stall_count + 1;
        end
    end

endmodule
